// ===== rtl/core/tcp_segment_checksum_top_defines.svh =====
// ----------------------------------------------------------------------------
// TCP segment checksum: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TCP_SEGMENT_CHECKSUM_TOP_DEFINES_SVH
`define TCP_SEGMENT_CHECKSUM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP segment checksum package
// Command word passed from the byte front end to the summing back end,
// fixed constants and the ones' complement adder.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    localparam logic [15:0] TCP_PROTOCOL  = 16'd6;
    localparam logic [15:0] CSUM_POS_HI   = 16'd16;
    localparam logic [15:0] CSUM_POS_LO   = 16'd17;
    localparam logic [15:0] LENGTH_MAX    = 16'hFFFF;

    // One command per accepted byte.
    typedef struct packed {
        logic        start;       // load the sum with the pseudo header
        logic [15:0] pseudo;      // folded pseudo header without the length
        logic        word_valid;  // a 16-bit word completed with this byte
        logic [15:0] word;
        logic        last;        // close the segment and emit a result
        logic [15:0] tail;        // padded odd byte plus segment length, folded
        logic [15:0] length;
        logic        overflow;
    } t_cmd;

    // 16-bit ones' complement addition with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== rtl/core/tcp_segment_checksum_top.sv =====
// ----------------------------------------------------------------------------
// TCP segment checksum with IPv4 pseudo header
// Streams a segment one byte per word and returns checksum and length.
// ----------------------------------------------------------------------------
// The block takes one segment byte per clock while the queue has room, with no gaps
// required between segments: the front end classifies each byte combinationally,
// a four-word command queue decouples it from the back end, and the back end adds
// one ones' complement word per cycle into the running sum unless a closing word
// waits for the result register to free. A result is registered when the closing
// command leaves the queue, and the input keeps flowing while that result waits to
// be taken until the queue fills. The addresses are sampled with the first byte only.
// ----------------------------------------------------------------------------
`include "tcp_segment_checksum_top_defines.svh"

module tcp_segment_checksum_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_byte, source_address, destination_address
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // checksum_value, segment_length
    output logic        m_axis_tuser    // length_overflow
);

    logic          q_full, q_valid, push, pop;
    tcs_pkg::t_cmd f_cmd, q_cmd;

    tcs_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (s_axis_tvalid),
        .o_ready               (s_axis_tready),
        .i_data_byte           (s_axis_tdata[7:0]),
        .i_last_byte           (s_axis_tlast),
        .i_source_address      (s_axis_tdata[39:8]),
        .i_destination_address (s_axis_tdata[71:40]),
        .i_full                (q_full),
        .o_push                (push),
        .o_cmd                 (f_cmd)
    );

    tcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    tcs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_cmd             (q_cmd),
        .o_pop             (pop),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_checksum_value  (m_axis_tdata[15:0]),
        .o_segment_length  (m_axis_tdata[31:16]),
        .o_length_overflow (m_axis_tuser)
    );

    // A finished checksum is never reported as zero.
    `TCS_ASSERT_NOW(a_csum_nonzero, i_clk, i_rst_n, m_axis_tvalid,
                    m_axis_tdata[15:0] != 16'd0, "checksum word of zero")
    // Every segment holds at least one byte.
    `TCS_ASSERT_NOW(a_len_nonzero, i_clk, i_rst_n, m_axis_tvalid,
                    m_axis_tdata[31:16] != 16'd0, "segment length of zero")
    // The overflow flag comes only with a saturated length.
    `TCS_ASSERT_NOW(a_ovf_sat, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
                    m_axis_tdata[31:16] == 16'hFFFF, "overflow without saturated length")
    // A closing word leaving the queue always produces a result next cycle.
    `TCS_ASSERT_NEXT(a_last_result, i_clk, i_rst_n, pop && q_cmd.last,
                     m_axis_tvalid, "result lost after closing word")

endmodule

// ===== rtl/core/tcs_front.sv =====
// ----------------------------------------------------------------------------
// TCP segment checksum front end
// Tracks byte position, blanks the checksum field, pairs bytes into words and
// prepares the pseudo header and tail terms for the back end.
// ----------------------------------------------------------------------------
module tcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic [31:0]   i_source_address,
    input  logic [31:0]   i_destination_address,
    input  logic          i_full,
    output logic          o_push,
    output tcs_pkg::t_cmd o_cmd
);

    logic        r_mid, n_mid;
    logic        r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_count, n_count;
    logic        r_ovf, n_ovf;

    logic        cur_phase;
    logic [7:0]  cur_held;
    logic [15:0] cur_count;
    logic        cur_ovf;
    logic [7:0]  b_eff;
    logic [15:0] pad;
    logic [15:0] pseudo_a, pseudo_b;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        cur_phase = r_mid ? r_phase : 1'b0;
        cur_held  = r_mid ? r_held  : 8'd0;
        cur_count = r_mid ? r_count : 16'd0;
        cur_ovf   = r_mid ? r_ovf   : 1'b0;

        // The checksum field itself counts as zero.
        if (!cur_ovf && (cur_count == tcs_pkg::CSUM_POS_HI ||
                         cur_count == tcs_pkg::CSUM_POS_LO)) begin
            b_eff = 8'd0;
        end else begin
            b_eff = i_data_byte;
        end

        o_cmd            = '0;
        o_cmd.start      = !r_mid;
        pseudo_a         = tcs_pkg::oc_add(i_source_address[31:16], i_source_address[15:0]);
        pseudo_b         = tcs_pkg::oc_add(i_destination_address[31:16],
                                           i_destination_address[15:0]);
        o_cmd.pseudo     = tcs_pkg::oc_add(tcs_pkg::oc_add(pseudo_a, pseudo_b),
                                           tcs_pkg::TCP_PROTOCOL);

        if (!cur_phase) begin
            n_held  = b_eff;
            n_phase = 1'b1;
        end else begin
            o_cmd.word_valid = 1'b1;
            o_cmd.word       = {cur_held, b_eff};
            n_held           = 8'd0;
            n_phase          = 1'b0;
        end

        if (cur_count == tcs_pkg::LENGTH_MAX) begin
            n_ovf   = 1'b1;
            n_count = cur_count;
        end else begin
            n_ovf   = cur_ovf;
            n_count = cur_count + 16'd1;
        end

        pad            = n_phase ? {n_held, 8'd0} : 16'd0;
        o_cmd.last     = i_last_byte;
        o_cmd.tail     = tcs_pkg::oc_add(pad, n_count);
        o_cmd.length   = n_count;
        o_cmd.overflow = n_ovf;

        n_mid = !i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_phase <= 1'b0;
            r_held  <= 8'd0;
            r_count <= 16'd0;
            r_ovf   <= 1'b0;
        end else if (o_push) begin
            r_mid   <= n_mid;
            r_phase <= n_phase;
            r_held  <= n_held;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== rtl/core/tcs_queue.sv =====
// ----------------------------------------------------------------------------
// TCP segment checksum command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module tcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcs_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output tcs_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    tcs_pkg::t_cmd                 r_mem [tcs_pkg::QDEPTH];
    logic [tcs_pkg::QAW-1:0]       r_wr, r_rd;
    logic [tcs_pkg::QCW-1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == tcs_pkg::QCW'(tcs_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + tcs_pkg::QCW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - tcs_pkg::QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + tcs_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + tcs_pkg::QAW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/tcs_back.sv =====
// ----------------------------------------------------------------------------
// TCP segment checksum back end
// Keeps the running ones' complement sum and registers the finished result.
// ----------------------------------------------------------------------------
module tcs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tcs_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [15:0]   o_checksum_value,
    output logic [15:0]   o_segment_length,
    output logic          o_length_overflow
);

    logic [15:0] r_sum;
    logic [15:0] base, s1, s2, cs;
    logic        r_valid;
    logic [15:0] r_cs, r_len;
    logic        r_ovf;

    // A closing word may only leave the queue when the result register frees.
    assign o_pop = i_valid && (!i_cmd.last || !r_valid || i_ready);

    always_comb begin
        base = i_cmd.start ? i_cmd.pseudo : r_sum;
        s1   = tcs_pkg::oc_add(base, i_cmd.word_valid ? i_cmd.word : 16'd0);
        s2   = tcs_pkg::oc_add(s1, i_cmd.tail);
        cs   = ~s2;
        if (cs == 16'd0) begin
            cs = 16'hFFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sum <= s1;
            end
            if (o_pop && i_cmd.last) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.last) begin
            r_cs  <= cs;
            r_len <= i_cmd.length;
            r_ovf <= i_cmd.overflow;
        end
    end

    assign o_valid           = r_valid;
    assign o_checksum_value  = r_cs;
    assign o_segment_length  = r_len;
    assign o_length_overflow = r_ovf;

endmodule
